### rtl/i2a_pkg.sv
// Package for the integer-to-ASCII formatter: state and code types, widths,
// and the character lookup functions. No dependencies.
`timescale 1ns / 1ps

package i2a_pkg;

    localparam int MAG_W   = 32;
    localparam int BCD_DIG = 10;
    localparam int BCD_W   = 4 * BCD_DIG;
    localparam int BUF_W   = 64;
    localparam int NDIG_W  = 5;
    localparam int CNT_W   = 6;

    typedef enum logic [2:0] {
        OP_LIT   = 3'd0,
        OP_PCT   = 3'd1,
        OP_CHAR  = 3'd2,
        OP_SDEC  = 3'd3,
        OP_UDEC  = 3'd4,
        OP_HEXL  = 3'd5,
        OP_HEXU  = 3'd6,
        OP_PTR   = 3'd7
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_TRIM,
        ST_PREFIX,
        ST_DIGITS,
        ST_CHAR
    } state_t;

    typedef enum logic [1:0] {
        PFX_NONE,
        PFX_MINUS,
        PFX_HEX,
        PFX_NIL
    } pfx_t;

    typedef struct packed {
        logic             load;
        logic [MAG_W-1:0] mag;
    } dab_ctrl_t;

    function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic upper);
        logic [7:0] ch;
        begin
            if (nib < 4'd10) begin
                ch = 8'h30 + {4'd0, nib};
            end else if (upper) begin
                ch = 8'h37 + {4'd0, nib};
            end else begin
                ch = 8'h57 + {4'd0, nib};
            end
            return ch;
        end
    endfunction

    // Last index of each prefix string
    function automatic logic [2:0] prefix_last(input pfx_t kind);
        logic [2:0] n;
        begin
            unique case (kind)
                PFX_MINUS: n = 3'd0;
                PFX_HEX:   n = 3'd1;
                PFX_NIL:   n = 3'd4;
                default:   n = 3'd0;
            endcase
            return n;
        end
    endfunction

    function automatic logic [7:0] prefix_char(input pfx_t kind, input logic [2:0] idx);
        logic [7:0] ch;
        begin
            ch = 8'h3F;
            unique case (kind)
                PFX_MINUS: ch = 8'h2D;
                PFX_HEX:   ch = (idx == 3'd0) ? 8'h30 : 8'h78;
                PFX_NIL:
                begin
                    unique case (idx)
                        3'd0:    ch = 8'h28;
                        3'd1:    ch = 8'h6E;
                        3'd2:    ch = 8'h69;
                        3'd3:    ch = 8'h6C;
                        default: ch = 8'h29;
                    endcase
                end
                default:   ch = 8'h3F;
            endcase
            return ch;
        end
    endfunction

endpackage

### rtl/i2a_dabble.sv
// Shift-add-3 binary to BCD converter, one bit per cycle.
// Depends on i2a_pkg.
`timescale 1ns / 1ps

module i2a_dabble (
    input  logic                        clk,
    input  logic                        rst_n,
    input  i2a_pkg::dab_ctrl_t          ctrl,
    output logic [i2a_pkg::BCD_W-1:0]   bcd,
    output logic                        done
);
    import i2a_pkg::*;

    logic [MAG_W-1:0]  bin_reg;
    logic [MAG_W-1:0]  bin_next;
    logic [BCD_W-1:0]  bcd_reg;
    logic [BCD_W-1:0]  bcd_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic [BCD_W-1:0]  adj;

    always_comb
    begin
        // add 3 to every digit of 5 or more before the shift
        for (int i = 0; i < BCD_DIG; i++) begin
            if (bcd_reg[4*i +: 4] >= 4'd5) begin
                adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end else begin
                adj[4*i +: 4] = bcd_reg[4*i +: 4];
            end
        end
        bin_next = bin_reg;
        bcd_next = bcd_reg;
        cnt_next = cnt_reg;
        if (ctrl.load) begin
            bin_next = ctrl.mag;
            bcd_next = '0;
            cnt_next = CNT_W'(MAG_W);
        end else if (cnt_reg != '0) begin
            bcd_next = {adj[BCD_W-2:0], bin_reg[MAG_W-1]};
            bin_next = {bin_reg[MAG_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign bcd  = bcd_reg;
    assign done = (cnt_reg == '0);

endmodule

### rtl/integer_to_ascii_formatter_unit.sv
// Integer-to-ASCII formatter top level: request decode, sequencer and
// character emitter. Depends on i2a_pkg and i2a_dabble.
`timescale 1ns / 1ps

// Usage:
//   A request (op, value, alt_form) is taken at a rising edge with start high
//   and busy low. busy stays high until the last character has left.
//   Characters leave one per cycle on char_out, each marked by strobe for a
//   single cycle; last_char flags the final one. The receiver cannot stall,
//   so every strobe beat is consumed at the edge that ends it.
// Sequence per request:
//   literal, char, percent: the single character.
//   decimal: the shift-add-3 converter (one bit per cycle), then the trim
//     state, which drops leading zero digits one at a time down to one digit,
//     an optional '-', then the remaining digits.
//   hex: trim as above over 8 digits, optional "0x", the remaining digits.
//   pointer: "(nil)", or trim over 16 digits, "0x", the remaining digits.
// Reset returns the sequencer to idle; a request in flight is dropped.
module integer_to_ascii_formatter_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  op,
    input  logic [63:0] value,
    input  logic        alt_form,
    output logic        strobe,
    output logic [7:0]  char_out,
    output logic        last_char
);
    import i2a_pkg::*;

    state_t             state_reg;
    state_t             state_next;
    pfx_t               pfx_reg;
    pfx_t               pfx_next;
    logic [2:0]         pidx_reg;
    logic [2:0]         pidx_next;
    logic [BUF_W-1:0]   buf_reg;
    logic [BUF_W-1:0]   buf_next;
    logic [NDIG_W-1:0]  ndig_reg;
    logic [NDIG_W-1:0]  ndig_next;
    logic [7:0]         char_reg;
    logic [7:0]         char_next;
    logic               upper_reg;
    logic               upper_next;

    dab_ctrl_t          dab_ctrl;
    logic [BCD_W-1:0]   dab_bcd;
    logic               dab_done;

    logic               accept;
    logic [MAG_W-1:0]   low32;
    logic               top_zero;

    assign accept   = start && (state_reg == ST_IDLE);
    assign low32    = value[MAG_W-1:0];
    assign top_zero = (buf_reg[BUF_W-1 -: 4] == 4'd0);

    i2a_dabble u_dabble (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (dab_ctrl),
        .bcd   (dab_bcd),
        .done  (dab_done)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start) begin
                    unique case (op_t'(op))
                        OP_LIT, OP_PCT, OP_CHAR: state_next = ST_CHAR;
                        OP_SDEC, OP_UDEC:        state_next = ST_CONV;
                        OP_HEXL, OP_HEXU:        state_next = ST_TRIM;
                        OP_PTR:
                            state_next = (value == '0) ? ST_PREFIX : ST_TRIM;
                        default:                 state_next = ST_IDLE;
                    endcase
                end
            end
            ST_CONV:
            begin
                if (dab_done) begin
                    state_next = ST_TRIM;
                end
            end
            ST_TRIM:
            begin
                if (!(top_zero && ndig_reg > NDIG_W'(1))) begin
                    state_next = (pfx_reg == PFX_NONE) ? ST_DIGITS : ST_PREFIX;
                end
            end
            ST_PREFIX:
            begin
                if (pidx_reg == prefix_last(pfx_reg)) begin
                    state_next = (pfx_reg == PFX_NIL) ? ST_IDLE : ST_DIGITS;
                end
            end
            ST_DIGITS:
            begin
                if (ndig_reg == NDIG_W'(1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_CHAR:   state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Datapath registers and converter control
    always_comb
    begin
        pfx_next       = pfx_reg;
        pidx_next      = pidx_reg;
        buf_next       = buf_reg;
        ndig_next      = ndig_reg;
        char_next      = char_reg;
        upper_next     = upper_reg;
        dab_ctrl.load  = 1'b0;
        dab_ctrl.mag   = low32;
        unique case (state_reg)
            ST_IDLE:
            begin
                pidx_next  = '0;
                upper_next = 1'b0;
                pfx_next   = PFX_NONE;
                if (accept) begin
                    unique case (op_t'(op))
                        OP_LIT, OP_CHAR: char_next = value[7:0];
                        OP_PCT:          char_next = 8'h25;
                        OP_SDEC:
                        begin
                            dab_ctrl.load = 1'b1;
                            if (low32[MAG_W-1]) begin
                                dab_ctrl.mag = '0 - low32;
                                pfx_next     = PFX_MINUS;
                            end
                        end
                        OP_UDEC:         dab_ctrl.load = 1'b1;
                        OP_HEXL, OP_HEXU:
                        begin
                            buf_next   = {low32, {(BUF_W-MAG_W){1'b0}}};
                            ndig_next  = NDIG_W'(MAG_W / 4);
                            upper_next = (op_t'(op) == OP_HEXU);
                            pfx_next   = alt_form ? PFX_HEX : PFX_NONE;
                        end
                        OP_PTR:
                        begin
                            buf_next  = value;
                            ndig_next = NDIG_W'(BUF_W / 4);
                            pfx_next  = (value == '0) ? PFX_NIL : PFX_HEX;
                        end
                        default:         char_next = char_reg;
                    endcase
                end
            end
            ST_CONV:
            begin
                if (dab_done) begin
                    buf_next  = {dab_bcd, {(BUF_W-BCD_W){1'b0}}};
                    ndig_next = NDIG_W'(BCD_DIG);
                end
            end
            ST_TRIM:
            begin
                // drop one leading zero digit per cycle, keep at least one
                if (top_zero && ndig_reg > NDIG_W'(1)) begin
                    buf_next  = {buf_reg[BUF_W-5:0], 4'd0};
                    ndig_next = ndig_reg - 1'b1;
                end
            end
            ST_PREFIX: pidx_next = pidx_reg + 1'b1;
            ST_DIGITS:
            begin
                buf_next  = {buf_reg[BUF_W-5:0], 4'd0};
                ndig_next = ndig_reg - 1'b1;
            end
            ST_CHAR:   char_next = char_reg;
            default:   char_next = char_reg;
        endcase
    end

    // Outputs
    always_comb
    begin
        strobe    = 1'b0;
        last_char = 1'b0;
        char_out  = char_reg;
        unique case (state_reg)
            ST_PREFIX:
            begin
                strobe    = 1'b1;
                char_out  = prefix_char(pfx_reg, pidx_reg);
                last_char = (pfx_reg == PFX_NIL) && (pidx_reg == prefix_last(pfx_reg));
            end
            ST_DIGITS:
            begin
                strobe    = 1'b1;
                char_out  = hex_char(buf_reg[BUF_W-1 -: 4], upper_reg);
                last_char = (ndig_reg == NDIG_W'(1));
            end
            ST_CHAR:
            begin
                strobe    = 1'b1;
                last_char = 1'b1;
            end
            default:
            begin
                strobe    = 1'b0;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pfx_reg   <= pfx_next;
        pidx_reg  <= pidx_next;
        buf_reg   <= buf_next;
        ndig_reg  <= ndig_next;
        char_reg  <= char_next;
        upper_reg <= upper_next;
    end

endmodule

### tb/integer_to_ascii_formatter_unit_test.sv
// Self-checking bench for integer_to_ascii_formatter_unit: directed and random
// conversion requests, predicted character text checked beat by beat.
// Depends on i2a_pkg (op_t) and the formatter RTL.
`timescale 1ns / 1ps

module integer_to_ascii_formatter_unit_test;

    import i2a_pkg::*;

    localparam int RANDOM_REQUESTS = 300;
    localparam int CALM_TAIL       = 40;
    localparam int STALL_LIMIT     = 1000;
    localparam int DRAIN_CYCLES    = 80;

    typedef struct {
        op_t         kind;
        logic [63:0] arg;
        logic        alt;
    } request_t;

    typedef struct {
        logic [7:0] ch;
        logic       last;
    } text_beat_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    op_t         op;
    logic [63:0] value;
    logic        alt_form;
    logic        strobe;
    logic [7:0]  char_out;
    logic        last_char;

    request_t   pending_requests[$];
    text_beat_t expected_text[$];

    logic issued;
    int   gap_left;
    int   quiet_cycles;
    int   n_requests;
    int   n_chars;
    int   n_errors;
    int   n_per_op[8];

    integer_to_ascii_formatter_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .op        (op),
        .value     (value),
        .alt_form  (alt_form),
        .strobe    (strobe),
        .char_out  (char_out),
        .last_char (last_char)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Work out the text a request must produce and queue it.
    function automatic void predict_text(op_t kind, logic [63:0] arg, logic alt);
        logic [7:0]  txt[$];
        logic [7:0]  digs[$];
        logic [31:0] mag;
        logic [63:0] hv;
        logic [3:0]  nib;
        logic        upper;
        int          top;
        int          i;
        begin
            case (kind)
                OP_LIT, OP_CHAR:
                begin
                    txt.push_back(arg[7:0]);
                end
                OP_PCT:
                begin
                    txt.push_back(8'h25);
                end
                OP_SDEC, OP_UDEC:
                begin
                    mag = arg[31:0];
                    if (kind == OP_SDEC && mag[31]) begin
                        txt.push_back(8'h2D);
                        mag = 32'd0 - mag;
                    end
                    do begin
                        digs.push_front(8'h30 + 8'(mag % 32'd10));
                        mag = mag / 32'd10;
                    end while (mag != 32'd0);
                    foreach (digs[k]) txt.push_back(digs[k]);
                end
                default:
                begin
                    if (kind == OP_PTR && arg == 64'd0) begin
                        txt = '{8'h28, 8'h6E, 8'h69, 8'h6C, 8'h29};
                    end else begin
                        if (kind == OP_PTR || alt) begin
                            txt.push_back(8'h30);
                            txt.push_back(8'h78);
                        end
                        upper = (kind == OP_HEXU);
                        hv    = (kind == OP_PTR) ? arg : {32'd0, arg[31:0]};
                        top   = (kind == OP_PTR) ? 15 : 7;
                        // drop leading zero nibbles, keep at least one
                        while (top > 0 && hv[top*4 +: 4] == 4'd0) top--;
                        for (i = top; i >= 0; i--) begin
                            nib = hv[i*4 +: 4];
                            if (nib < 4'd10)
                                txt.push_back(8'h30 + {4'd0, nib});
                            else
                                txt.push_back((upper ? 8'h41 : 8'h61) + {4'd0, nib} - 8'd10);
                        end
                    end
                end
            endcase
            foreach (txt[k]) begin
                expected_text.push_back('{ch: txt[k], last: (k == txt.size() - 1)});
            end
        end
    endfunction

    // Request driver: present the head of the queue, idle in bursts.
    always @(negedge clk) begin
        if (rst_n) begin
            if (issued) begin
                pending_requests.pop_front();
            end
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                start    <= 1'b0;
            end else if (pending_requests.size() == 0) begin
                start <= 1'b0;
            end else if (pending_requests.size() > CALM_TAIL && $urandom_range(0, 5) == 0) begin
                gap_left <= $urandom_range(0, 7);
                start    <= 1'b0;
            end else begin
                start    <= 1'b1;
                op       <= pending_requests[0].kind;
                value    <= pending_requests[0].arg;
                alt_form <= pending_requests[0].alt;
            end
        end
    end

    // Monitor: predict on each accepted request, check each strobe beat.
    always @(posedge clk) begin
        if (!rst_n) begin
            issued       <= 1'b0;
            quiet_cycles <= 0;
        end else begin
            issued <= start && !busy;
            if (start && !busy) begin
                predict_text(op, value, alt_form);
                n_requests++;
                n_per_op[op]++;
            end
            if (strobe) begin
                n_chars++;
                if (expected_text.size() == 0) begin
                    $display("%0t: unexpected beat char_out=%02h last_char=%0b",
                             $time, char_out, last_char);
                    n_errors++;
                end else begin
                    if (char_out !== expected_text[0].ch) begin
                        $display("%0t: char_out expected %02h actual %02h",
                                 $time, expected_text[0].ch, char_out);
                        n_errors++;
                    end
                    if (last_char !== expected_text[0].last) begin
                        $display("%0t: last_char expected %0b actual %0b",
                                 $time, expected_text[0].last, last_char);
                        n_errors++;
                    end
                    expected_text.pop_front();
                end
            end
            if ((start && !busy) || strobe) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
                $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
                $display("FAIL");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        logic [63:0] v;
        op_t         kind;
        rst_n    = 1'b0;
        start    = 1'b0;
        op       = OP_LIT;
        value    = 64'd0;
        alt_form = 1'b0;
        gap_left = 0;
        n_requests = 0;
        n_chars    = 0;
        n_errors   = 0;
        foreach (n_per_op[k]) n_per_op[k] = 0;

        // Directed: field extremes, every op, the corner cases.
        pending_requests.push_back('{OP_LIT,  64'h0000_0000_0000_0000, 1'b0});
        pending_requests.push_back('{OP_LIT,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1});
        pending_requests.push_back('{OP_CHAR, 64'h1234_5678_9ABC_DE41, 1'b0});
        pending_requests.push_back('{OP_CHAR, 64'h0000_0000_0000_0080, 1'b1});
        pending_requests.push_back('{OP_PCT,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1});
        pending_requests.push_back('{OP_PCT,  64'h0000_0000_0000_0000, 1'b0});
        pending_requests.push_back('{OP_SDEC, 64'h0000_0000_0000_0000, 1'b0});
        pending_requests.push_back('{OP_SDEC, 64'hFFFF_FFFF_7FFF_FFFF, 1'b1});
        pending_requests.push_back('{OP_SDEC, 64'h0000_0000_8000_0000, 1'b0});
        pending_requests.push_back('{OP_SDEC, 64'hA5A5_A5A5_FFFF_FFFF, 1'b0});
        pending_requests.push_back('{OP_UDEC, 64'h0000_0000_0000_0000, 1'b1});
        pending_requests.push_back('{OP_UDEC, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0});
        pending_requests.push_back('{OP_UDEC, 64'h0000_0000_3B9A_CA00, 1'b0});
        pending_requests.push_back('{OP_HEXL, 64'h0000_0000_0000_0000, 1'b0});
        pending_requests.push_back('{OP_HEXL, 64'hFFFF_FFFF_0000_0000, 1'b1});
        pending_requests.push_back('{OP_HEXL, 64'h0000_0000_DEAD_BEEF, 1'b1});
        pending_requests.push_back('{OP_HEXL, 64'h0000_0000_0000_000A, 1'b0});
        pending_requests.push_back('{OP_HEXU, 64'h0000_0000_ABCD_EF01, 1'b1});
        pending_requests.push_back('{OP_HEXU, 64'h1234_5678_FFFF_FFFF, 1'b0});
        pending_requests.push_back('{OP_HEXU, 64'h0000_0000_0000_0000, 1'b1});
        pending_requests.push_back('{OP_PTR,  64'h0000_0000_0000_0000, 1'b0});
        pending_requests.push_back('{OP_PTR,  64'h0000_0000_0000_0000, 1'b1});
        pending_requests.push_back('{OP_PTR,  64'h0000_0000_0000_0001, 1'b1});
        pending_requests.push_back('{OP_PTR,  64'hFFFF_FFFF_FFFF_FFFF, 1'b0});
        pending_requests.push_back('{OP_PTR,  64'h8000_0000_0000_0000, 1'b0});

        // Random: mix full-width values with short ones and sign boundaries.
        repeat (RANDOM_REQUESTS) begin
            kind = op_t'($urandom_range(0, 7));
            case ($urandom_range(0, 4))
                0: v = {$urandom, $urandom};
                1: v = {$urandom, $urandom} >> $urandom_range(0, 63);
                2: v = {$urandom, 32'($urandom_range(0, 20))};
                3: v = {$urandom, ($urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF)};
                default: v = $urandom_range(0, 1) ? 64'd0 : {$urandom, 32'd0};
            endcase
            pending_requests.push_back('{kind, v, 1'($urandom_range(0, 1))});
        end

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        while (pending_requests.size() != 0 || expected_text.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        foreach (expected_text[k]) begin
            $display("%0t: missing beat char_out=%02h last_char=%0b",
                     $time, expected_text[k].ch, expected_text[k].last);
            n_errors++;
        end
        $display("Checked %0d requests (lit %0d pct %0d chr %0d sdec %0d udec %0d",
                 n_requests, n_per_op[OP_LIT], n_per_op[OP_PCT], n_per_op[OP_CHAR],
                 n_per_op[OP_SDEC], n_per_op[OP_UDEC]);
        $display("  hexl %0d hexu %0d ptr %0d), %0d characters, %0d mismatches",
                 n_per_op[OP_HEXL], n_per_op[OP_HEXU], n_per_op[OP_PTR], n_chars, n_errors);
        if (n_errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
